// ===== rtl/mutsu_pkg.sv =====
package mutsu_pkg;

  localparam int SIZE_W    = 40;
  localparam int PCT_W     = 15;
  localparam int SLOPE_W   = 16;
  localparam int DIV_W     = 55;
  localparam int DIVR_W    = 40;
  localparam int DIV_CNT_W = 6;

  localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;
  localparam logic [SIZE_W-1:0] CEIL_RESET = 40'd1048576;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [PCT_W-1:0] sat_pct(input logic [DIV_W-1:0] q);
    logic [PCT_W-1:0] r;
    if (q > DIV_W'(PCT_FULL)) begin
      r = PCT_FULL;
    end else begin
      r = q[PCT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/memory_usage_trend_slope_unit.sv =====
// Memory usage trend unit.
// s_axis carries one statistics sample per transfer; m_axis returns one result
// per sample. cfg_* writes the memory ceiling (reset value 1048576) and is
// always ready; write it only while the unit is idle.
// Each sample yields guest use, swapped size and percent used (Q7.8). Percents
// enter a circular window of WINDOW entries; once it is full every sample also
// yields the least-squares slope in signed Q8.8 with tuser set. Before that the
// slope reads 0 and tuser is low.
// Each sample takes one 55-step pass through the shared restoring divider for
// its percent. Once the window is full it then walks the window memory, one
// entry per cycle, and takes a second 55-step pass for the slope.
// One sample is in work at a time; s_axis_tready returns in the same cycle as
// its result is posted on m_axis.
// Reset empties the window and clears the slope. A stalled m_axis holds its
// result; the next sample can be taken meanwhile and waits at the output.
module memory_usage_trend_slope_unit
  import mutsu_pkg::*;
#(
  parameter int WINDOW = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // available_size [39:0], unused_size [79:40], resident_size [119:80]
  input  logic [119:0] s_axis_tdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // guest_used [39:0], swapped_size [79:40], percent_used [94:80],
  // trend_slope [110:95], zero [111]
  output logic [111:0] m_axis_tdata,
  // slope_valid [0]
  output logic         m_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [39:0]  cfg_data_i,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o
);

  localparam int IW   = $clog2(WINDOW);
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int SYW  = PCT_W + IW;
  localparam int SXYW = PCT_W + 2 * IW;
  localparam int NUMW = PCT_W + 3 * IW + 2;
  localparam longint SX  = WINDOW * (WINDOW - 1) / 2;
  localparam longint DEN = WINDOW * WINDOW * (WINDOW * WINDOW - 1) / 12;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIVP  = 4'd1;
  localparam logic [3:0] S_WAITP = 4'd2;
  localparam logic [3:0] S_WRITE = 4'd3;
  localparam logic [3:0] S_WALK  = 4'd4;
  localparam logic [3:0] S_NUM1  = 4'd5;
  localparam logic [3:0] S_NUM2  = 4'd6;
  localparam logic [3:0] S_DIVS  = 4'd7;
  localparam logic [3:0] S_WAITS = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0]              state_q;
  logic [SIZE_W-1:0]       ceil_q;
  logic [SIZE_W-1:0]       guest_q;
  logic [SIZE_W-1:0]       swap_q;
  logic [PCT_W-1:0]        pct_q;
  logic [IW-1:0]           wr_q;
  logic [IW-1:0]           rd_q;
  logic [CW-1:0]           fill_q;
  logic [CW-1:0]           cnt_q;
  logic [SYW-1:0]          sy_q;
  logic [SXYW-1:0]         sxy_q;
  logic signed [NUMW-1:0]  t_q;
  logic signed [NUMW-1:0]  num_q;
  logic signed [SLOPE_W-1:0] slope_q;
  logic                    valid_q;

  logic [PCT_W-1:0]        mem [WINDOW];
  logic [PCT_W-1:0]        rdata_q;

  logic                    out_valid_q;
  logic [SIZE_W-1:0]       out_guest_q;
  logic [SIZE_W-1:0]       out_swap_q;
  logic [PCT_W-1:0]        out_pct_q;
  logic [SLOPE_W-1:0]      out_slope_q;
  logic                    out_flag_q;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic [SIZE_W-1:0]       avail;
  logic [SIZE_W-1:0]       unused;
  logic [SIZE_W-1:0]       resident;
  logic [SIZE_W-1:0]       guest;
  logic [SIZE_W+6:0]       guest100;
  logic [NUMW-1:0]         num_mag;
  logic [IW-1:0]           wr_next;
  logic [IW-1:0]           rd_next;
  logic [IW-1:0]           idx;
  logic [PCT_W+IW-1:0]     prod;
  logic [PCT_W-1:0]        q_sat;
  logic                    emit_ok;

  assign avail    = s_axis_tdata[39:0];
  assign unused   = s_axis_tdata[79:40];
  assign resident = s_axis_tdata[119:80];
  assign guest    = (avail > unused) ? avail - unused : '0;

  assign guest100 = ((SIZE_W+7)'(guest_q) << 6) + ((SIZE_W+7)'(guest_q) << 5)
                  + ((SIZE_W+7)'(guest_q) << 2);
  assign num_mag  = num_q[NUMW-1] ? NUMW'(-num_q) : NUMW'(num_q);

  assign wr_next  = (wr_q == IW'(WINDOW - 1)) ? '0 : wr_q + 1'b1;
  assign rd_next  = (rd_q == IW'(WINDOW - 1)) ? '0 : rd_q + 1'b1;
  assign idx      = IW'(cnt_q - 1'b1);
  assign prod     = (PCT_W+IW)'(idx) * (PCT_W+IW)'(rdata_q);
  assign q_sat    = sat_pct(div_rsp.quotient);
  assign emit_ok  = !out_valid_q || m_axis_tready;

  always_comb begin
    div_req.start = (state_q == S_DIVP) || (state_q == S_DIVS);
    if (state_q == S_DIVP) begin
      div_req.dividend = {guest100, 8'b0};
      div_req.divisor  = ceil_q;
    end else begin
      div_req.dividend = (DIV_W'(num_mag) << 1) + DIV_W'(DEN);
      div_req.divisor  = DIVR_W'(2 * DEN);
    end
  end

  mutsu_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) begin
      mem[wr_q] <= pct_q;
    end
    rdata_q <= mem[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ceil_q      <= CEIL_RESET;
      wr_q        <= '0;
      fill_q      <= '0;
      slope_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        ceil_q <= cfg_data_i;
      end
      if ((state_q == S_EMIT) && emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state_q <= S_DIVP;
          end
        end
        S_DIVP: begin
          state_q <= S_WAITP;
        end
        S_WAITP: begin
          if (div_rsp.done) begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          wr_q <= wr_next;
          if (fill_q >= CW'(WINDOW - 1)) begin
            fill_q  <= CW'(WINDOW);
            state_q <= S_WALK;
          end else begin
            fill_q  <= fill_q + 1'b1;
            state_q <= S_EMIT;
          end
        end
        S_WALK: begin
          if (cnt_q == CW'(WINDOW)) begin
            state_q <= S_NUM1;
          end
        end
        S_NUM1: begin
          state_q <= S_NUM2;
        end
        S_NUM2: begin
          state_q <= S_DIVS;
        end
        S_DIVS: begin
          state_q <= S_WAITS;
        end
        S_WAITS: begin
          if (div_rsp.done) begin
            slope_q <= num_q[NUMW-1] ? -SLOPE_W'(q_sat) : SLOPE_W'(q_sat);
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        guest_q <= guest;
        swap_q  <= (guest > resident) ? guest - resident : '0;
      end
      S_WAITP: begin
        pct_q   <= q_sat;
        valid_q <= 1'b0;
      end
      S_WRITE: begin
        rd_q  <= wr_next;
        cnt_q <= '0;
        sy_q  <= '0;
        sxy_q <= '0;
      end
      S_WALK: begin
        if (cnt_q != CW'(WINDOW)) begin
          rd_q  <= rd_next;
          cnt_q <= cnt_q + 1'b1;
        end
        if (cnt_q != '0) begin
          sy_q  <= sy_q + SYW'(rdata_q);
          sxy_q <= sxy_q + SXYW'(prod);
        end
      end
      S_NUM1: begin
        t_q <= NUMW'(sxy_q) * NUMW'(WINDOW);
      end
      S_NUM2: begin
        num_q <= t_q - NUMW'(sy_q) * NUMW'(SX);
      end
      S_WAITS: begin
        valid_q <= 1'b1;
      end
      S_EMIT: begin
        if (emit_ok) begin
          out_guest_q <= guest_q;
          out_swap_q  <= swap_q;
          out_pct_q   <= pct_q;
          out_slope_q <= slope_q;
          out_flag_q  <= valid_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_slope_q, out_pct_q, out_swap_q, out_guest_q};
  assign m_axis_tuser  = out_flag_q;

endmodule

// ===== rtl/mutsu_div.sv =====
module mutsu_div
  import mutsu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVR_W-1:0]    rem_q;
  logic [DIV_W-1:0]     quo_q;
  logic [DIVR_W-1:0]    dsr_q;

  logic [DIVR_W:0]      shifted;
  logic                 ge;
  logic [DIVR_W:0]      diff;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/mutsu_checker.sv =====
module mutsu_checker
  import mutsu_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second sample taken while one is in work");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[94:80] <= PCT_FULL)
    else $error("percent above full scale");

  a_slope_zero_unfilled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[110:95] == '0)
    else $error("slope nonzero before window full");

  a_swap_le_guest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[79:40] <= m_axis_tdata[39:0])
    else $error("swapped size above guest use");

endmodule

bind memory_usage_trend_slope_unit mutsu_checker u_mutsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

// ===== tb/sv/memory_usage_trend_slope_unit_tb.sv =====
module memory_usage_trend_slope_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mutsu_pkg::*;

  localparam int WINDOW      = 16;
  localparam int HOLD_CYCLES = 900;
  localparam int IDLE_LIMIT  = 6000;
  localparam int TAIL_CYCLES = 300;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  typedef struct packed {
    logic [SIZE_W-1:0] resident;
    logic [SIZE_W-1:0] unused;
    logic [SIZE_W-1:0] avail;
  } sample_t;

  typedef struct packed {
    logic                      valid;
    logic signed [SLOPE_W-1:0] slope;
    logic [PCT_W-1:0]          pct;
    logic [SIZE_W-1:0]         swapped;
    logic [SIZE_W-1:0]         guest;
  } usage_t;

  class trend_scoreboard;
    logic [SIZE_W-1:0]         ceiling;
    logic [PCT_W-1:0]          pct_win [WINDOW];
    int unsigned               fill;
    logic signed [SLOPE_W-1:0] slope;
    usage_t                    expected_usage[$];
    int unsigned               samples;
    int unsigned               results_seen;
    int unsigned               slope_results;
    int unsigned               mismatches;

    function new();
      ceiling = CEIL_RESET;
      fill = 0;
      slope = '0;
      samples = 0;
      results_seen = 0;
      slope_results = 0;
      mismatches = 0;
      foreach (pct_win[i]) pct_win[i] = '0;
    endfunction

    function logic signed [SLOPE_W-1:0] fit_trend();
      longint sx, sy, sxy, sxx, num, den;
      longint unsigned mag, q;
      sx = 0;
      sy = 0;
      sxy = 0;
      sxx = 0;
      for (int i = 0; i < WINDOW; i++) begin
        sx += i;
        sxx += longint'(i) * longint'(i);
        sy += longint'(pct_win[i]);
        sxy += longint'(i) * longint'(pct_win[i]);
      end
      num = WINDOW * sxy - sx * sy;
      den = WINDOW * sxx - sx * sx;
      if (den <= 0) return '0;
      mag = (num < 0) ? -num : num;
      // round half away from zero
      q = (mag * 2 + den) / (2 * den);
      if (q > PCT_FULL) q = PCT_FULL;
      return (num < 0) ? -SLOPE_W'(q) : SLOPE_W'(q);
    endfunction

    function void note_sample(sample_t s);
      usage_t u;
      logic [63:0] wide;
      u.guest = (s.avail > s.unused) ? s.avail - s.unused : '0;
      u.swapped = (u.guest > s.resident) ? u.guest - s.resident : '0;
      if (ceiling == '0) begin
        u.pct = PCT_FULL;
      end else begin
        wide = (64'(u.guest) * 64'(PCT_FULL)) / 64'(ceiling);
        u.pct = (wide > 64'(PCT_FULL)) ? PCT_FULL : wide[PCT_W-1:0];
      end
      if (fill < WINDOW) begin
        pct_win[fill] = u.pct;
        fill++;
      end else begin
        for (int i = 0; i < WINDOW - 1; i++) pct_win[i] = pct_win[i+1];
        pct_win[WINDOW-1] = u.pct;
      end
      u.valid = 1'b0;
      if (fill == WINDOW) begin
        slope = fit_trend();
        u.valid = 1'b1;
      end
      u.slope = slope;
      expected_usage.insert(expected_usage.size(), u);
      samples++;
    endfunction

    function void check_result(logic [111:0] data, logic user);
      usage_t want, got;
      logic pad;
      got.guest = data[39:0];
      got.swapped = data[79:40];
      got.pct = data[94:80];
      got.slope = data[110:95];
      got.valid = user;
      pad = data[111];
      results_seen++;
      if (expected_usage.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: guest %0d swapped %0d pct %0d slope %0d valid %0b",
                   results_seen, got.guest, got.swapped, got.pct, got.slope, got.valid);
        return;
      end
      want = expected_usage.pop_front();
      if (want.valid) slope_results++;
      if (got != want || pad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch (expected / actual):", results_seen);
          $display("  guest %0d / %0d  swapped %0d / %0d  pct %0d / %0d",
                   want.guest, got.guest, want.swapped, got.swapped, want.pct, got.pct);
          $display("  slope %0d / %0d  valid %0b / %0b  pad 0 / %0b",
                   want.slope, got.slope, want.valid, got.valid, pad);
        end
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [119:0] s_axis_tdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [39:0]  cfg_data_i;
  logic         cfg_valid_i;
  logic         cfg_ready_o;

  trend_scoreboard sb;
  int          burst_left;
  int unsigned idle_cycles;
  int unsigned ceilings_set;

  memory_usage_trend_slope_unit #(
    .WINDOW(WINDOW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_data_i   (cfg_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [SIZE_W-1:0] rand40();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[SIZE_W-1:0];
  endfunction

  function automatic sample_t pack_sample(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] u,
                                          logic [SIZE_W-1:0] r);
    sample_t s;
    s.avail = a;
    s.unused = u;
    s.resident = r;
    return s;
  endfunction

  function automatic logic [SIZE_W-1:0] guest_for(int target);
    logic [63:0] g;
    g = (64'(target) * 64'(sb.ceiling) + 64'(PCT_FULL) - 1) / 64'(PCT_FULL);
    if (g > 64'(SIZE_MAX)) g = 64'(SIZE_MAX);
    return g[SIZE_W-1:0];
  endfunction

  function automatic sample_t shape_sample(int target);
    logic [63:0]       g, u;
    logic [SIZE_W-1:0] delta;
    sample_t           s;
    if (target < 0) target = 0;
    if (sb.ceiling == '0) g = 64'(rand40() >> $urandom_range(0, 40));
    else g = 64'(guest_for(target));
    u = 64'(rand40() >> $urandom_range(0, 40));
    if (g + u > 64'(SIZE_MAX)) u = 64'(SIZE_MAX) - g;
    s.avail = SIZE_W'(g + u);
    s.unused = SIZE_W'(u);
    if ($urandom_range(0, 15) == 0) {s.avail, s.unused} = {s.unused, s.avail};
    delta = rand40() >> $urandom_range(4, 40);
    case ($urandom_range(0, 3))
      0: s.resident = rand40();
      1: s.resident = (SIZE_W'(g) >= delta) ? SIZE_W'(g) - delta : '0;
      2: s.resident = SIZE_W'(g);
      default: s.resident = $urandom_range(0, 1) ? SIZE_MAX : '0;
    endcase
    return s;
  endfunction

  task automatic offer(sample_t s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 250);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tdata = s;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(s);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left = 0;
    while (sb.expected_usage.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ceiling(logic [SIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_data_i = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.ceiling = value;
    ceilings_set++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_directed();
    logic [SIZE_W-1:0] v;
    offer(pack_sample(guest_for(68), '0, '0));
    offer(pack_sample('0, SIZE_MAX, SIZE_MAX));
    offer(pack_sample(SIZE_MAX, SIZE_MAX, '0));
    offer(pack_sample(40'd5, 40'd9, SIZE_MAX));
    repeat (11) begin
      v = rand40();
      offer(pack_sample(v, v, rand40()));
    end
    // window now holds one bump at the oldest slot: slope lands on a half
    offer(pack_sample('0, '0, '0));
    offer(pack_sample(guest_for(68), '0, '0));
    offer(pack_sample(SIZE_MAX, '0, '0));
    offer(pack_sample(SIZE_MAX, 40'd1, SIZE_MAX));
    offer(pack_sample(sb.ceiling, '0, sb.ceiling - 1));
    offer(pack_sample(sb.ceiling - 1, '0, sb.ceiling));
    offer(pack_sample(sb.ceiling + 1, '0, '0));
  endtask

  task automatic run_trend(int count);
    int      level, step, run_left, target;
    sample_t s;
    run_left = 0;
    level = 0;
    step = 0;
    repeat (count) begin
      if (run_left == 0) begin
        level = $urandom_range(0, 26000);
        step = int'($urandom_range(0, 1600)) - 800;
        run_left = $urandom_range(16, 60);
      end
      run_left--;
      if ($urandom_range(0, 7) == 0) begin
        s = pack_sample(rand40(), rand40(), rand40());
      end else begin
        target = level + int'($urandom_range(0, 400)) - 200;
        s = shape_sample(target);
        level += step;
        if (level < 0) level = 0;
        if (level > 27000) level = 27000;
      end
      offer(s);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : rx_stall
    int mode, span;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk_i);
        // hold off long enough for the unit to back up onto s_axis
        if (!held && sb.results_seen >= 150) begin
          held = 1'b1;
          m_axis_tready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
        end
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = 1'($urandom_range(0, 1));
          2: m_axis_tready = ($urandom_range(0, 3) == 0);
          default: m_axis_tready = ~m_axis_tready;
        endcase
      end
    end
  end

  initial begin : main
    logic [SIZE_W-1:0] ceil_val;
    sb = new();
    burst_left = 0;
    idle_cycles = 0;
    ceilings_set = 0;
    s_axis_tdata = '0;
    s_axis_tvalid = 1'b0;
    cfg_data_i = '0;
    cfg_valid_i = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    wait_idle();
    write_ceiling(40'd1);
    run_trend(20);
    wait_idle();
    write_ceiling(SIZE_MAX);
    run_trend(30);
    wait_idle();
    write_ceiling('0);
    run_trend(20);
    wait_idle();
    for (int p = 0; p < 9; p++) begin
      if (p == 4) begin
        ceil_val = CEIL_RESET;
      end else begin
        ceil_val = rand40() >> $urandom_range(0, 39);
        if (ceil_val == '0) ceil_val = 40'd1;
      end
      write_ceiling(ceil_val);
      run_trend(60);
      wait_idle();
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (sb.expected_usage.size() != 0)
      $display("%0d expected results never arrived", sb.expected_usage.size());
    $display("Covered %0d samples over %0d ceiling writes, zero and full-scale ceilings included;",
             sb.samples, ceilings_set);
    $display("%0d results checked, %0d carrying a full-window slope, %0d mismatches.",
             sb.results_seen, sb.slope_results, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_usage.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== memory_usage_trend_slope_unit.f =====
rtl/mutsu_pkg.sv
rtl/mutsu_div.sv
rtl/memory_usage_trend_slope_unit.sv
rtl/mutsu_checker.sv
tb/sv/memory_usage_trend_slope_unit_tb.sv
